FILE: design/hds_pkg.sv
// Shared types and constants for the 1-D heat diffusion step unit.
// Holds cell store sizing, field widths, mode and register codes, and the
// command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package hds_pkg;

  localparam int MAX_CELLS = 1024;
  localparam int ADDR_W    = $clog2(MAX_CELLS);
  localparam int LEN_W     = 11;
  localparam int GAIN_W    = 15;
  localparam int VALUE_W   = 32;
  localparam int MODE_W    = 2;

  localparam int S_TDATA_W = 48;
  localparam int S_TUSER_W = MODE_W;
  localparam int M_TDATA_W = VALUE_W;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = GAIN_W;

  localparam logic [GAIN_W-1:0] GAIN_RESET  = GAIN_W'(655);
  localparam logic [LEN_W-1:0]  CELLS_RESET = LEN_W'(MAX_CELLS);
  localparam logic [LEN_W-1:0]  MIN_STEP_LEN = LEN_W'(3);

  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STEP  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS = 1'b1;

  typedef struct packed {
    logic              take_item;
    logic              item_wr;
    logic              item_rd;
    logic              step_rd;
    logic              clear_wr;
    logic [ADDR_W-1:0] addr;
    logic              load_result;
  } hds_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              idx_ok;
    logic              step_ok;
    logic [LEN_W-1:0]  line_len;
    logic              pipe_busy;
    logic              out_free;
  } hds_status_t;

endpackage

FILE: design/hds_ctrl.sv
// Controller for the heat diffusion step unit: clear sweep after reset,
// item decode and the read walk of a time step. Depends on hds_pkg.
`timescale 1ns / 1ps

module hds_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output hds_pkg::hds_cmd_t   cmd,
  input  hds_pkg::hds_status_t status
);
  import hds_pkg::*;

  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_EXEC    = 3'd2;
  localparam logic [2:0] ST_STEP_RD = 3'd3;
  localparam logic [2:0] ST_DRAIN   = 3'd4;
  localparam logic [2:0] ST_FINISH  = 3'd5;

  logic [2:0]        state, state_next;
  logic [ADDR_W-1:0] cnt, cnt_next;
  logic              last_cell;

  assign s_tready  = (state == ST_IDLE);
  assign last_cell = ({1'b0, cnt} == (status.line_len - LEN_W'(1)));

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.addr   = cnt;
    case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (cnt == ADDR_W'(MAX_CELLS - 1)) begin
          state_next = ST_IDLE;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + ADDR_W'(1);
        end
      end
      ST_IDLE: begin
        cnt_next = '0;
        if (s_tvalid) begin
          cmd.take_item = 1'b1;
          state_next    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_FINISH;
        case (status.mode)
          MODE_WRITE: cmd.item_wr = status.idx_ok;
          MODE_READ:  cmd.item_rd = status.idx_ok;
          MODE_STEP: begin
            if (status.step_ok) state_next = ST_STEP_RD;
          end
          default: ;
        endcase
      end
      ST_STEP_RD: begin
        // stream old values out one cell a cycle; writes trail behind through the window, lap and product registers
        cmd.step_rd = 1'b1;
        if (last_cell) begin
          state_next = ST_DRAIN;
        end else begin
          cnt_next = cnt + ADDR_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.load_result = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

FILE: design/hds_datapath.sv
// Datapath of the heat diffusion step unit: cell store, configuration
// registers, stencil pipeline and result register. Depends on hds_pkg.
`timescale 1ns / 1ps

module hds_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [hds_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic [hds_pkg::S_TUSER_W-1:0] s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [hds_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                          m_tuser,
  input  logic                          cfg_valid,
  input  logic [hds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hds_pkg::CFG_DATA_W-1:0] cfg_data,
  input  hds_pkg::hds_cmd_t             cmd,
  output hds_pkg::hds_status_t          status
);
  import hds_pkg::*;

  // configuration
  logic [GAIN_W-1:0] gain;
  logic [LEN_W-1:0]  cells_in_use;
  logic [LEN_W-1:0]  line_len;

  // latched item
  logic [MODE_W-1:0]  item_mode;
  logic [ADDR_W-1:0]  item_idx;
  logic [VALUE_W-1:0] item_value;

  // cell store
  logic [VALUE_W-1:0] mem [MAX_CELLS];
  logic [VALUE_W-1:0] rdata;
  logic               we, re;
  logic [ADDR_W-1:0]  waddr, raddr;
  logic [VALUE_W-1:0] wdata;

  // stencil pipeline
  logic               rd_valid;
  logic [ADDR_W-1:0]  rd_idx;
  logic [VALUE_W-1:0] win_l, win_m, win_r;
  logic               win_valid;
  logic [ADDR_W-1:0]  win_idx;
  logic signed [34:0] lap;
  logic [VALUE_W-1:0] lap_mid;
  logic [ADDR_W-1:0]  lap_idx;
  logic               lap_valid;
  logic signed [50:0] prod;
  logic [VALUE_W-1:0] prod_mid;
  logic [ADDR_W-1:0]  prod_idx;
  logic               prod_valid;
  logic signed [34:0] lap_calc;
  logic signed [50:0] prod_rnd;
  logic signed [35:0] sum;
  logic [VALUE_W-1:0] new_value;

  logic out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain         <= GAIN_RESET;
      cells_in_use <= CELLS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GAIN:  gain         <= cfg_data;
        REG_CELLS: cells_in_use <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign line_len = (cells_in_use > LEN_W'(MAX_CELLS)) ? LEN_W'(MAX_CELLS) : cells_in_use;

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      item_mode  <= s_tuser;
      item_idx   <= s_tdata[ADDR_W-1:0];
      item_value <= s_tdata[10 +: VALUE_W];
    end
  end

  // one write port shared by the clear sweep, item writes and step updates
  always_comb begin
    we    = 1'b0;
    waddr = cmd.addr;
    wdata = '0;
    if (cmd.clear_wr) begin
      we = 1'b1;
    end else if (cmd.item_wr) begin
      we    = 1'b1;
      waddr = item_idx;
      wdata = item_value;
    end else if (prod_valid) begin
      we    = 1'b1;
      waddr = prod_idx;
      wdata = new_value;
    end
  end

  assign re    = cmd.item_rd | cmd.step_rd;
  assign raddr = cmd.item_rd ? item_idx : cmd.addr;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  // window holds old values of cells j-2, j-1, j; reads always run ahead of writes
  assign lap_calc = $signed({{3{win_l[31]}}, win_l}) + $signed({{3{win_r[31]}}, win_r})
                  - $signed({{2{win_m[31]}}, win_m, 1'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid   <= 1'b0;
      win_valid  <= 1'b0;
      lap_valid  <= 1'b0;
      prod_valid <= 1'b0;
    end else begin
      rd_valid   <= cmd.step_rd;
      win_valid  <= rd_valid && (rd_idx >= ADDR_W'(2));
      lap_valid  <= win_valid;
      prod_valid <= lap_valid;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= cmd.addr;
    if (rd_valid) begin
      win_r   <= rdata;
      win_m   <= win_r;
      win_l   <= win_m;
      win_idx <= rd_idx - ADDR_W'(1);
    end
    lap      <= lap_calc;
    lap_mid  <= win_m;
    lap_idx  <= win_idx;
    prod     <= 51'($signed({1'b0, gain})) * 51'(lap);
    prod_mid <= lap_mid;
    prod_idx <= lap_idx;
  end

  // round half up, floor by 2^16, then saturate old + delta
  assign prod_rnd = prod + 51'sd32768;
  assign sum = $signed({{4{prod_mid[31]}}, prod_mid}) + $signed({prod_rnd[50], prod_rnd[50:16]});

  always_comb begin
    if (sum[35:31] == 5'b00000 || sum[35:31] == 5'b11111) begin
      new_value = sum[31:0];
    end else if (sum[35]) begin
      new_value = 32'h8000_0000;
    end else begin
      new_value = 32'h7FFF_FFFF;
    end
  end

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_result) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      m_tdata <= (item_mode == MODE_READ && status.idx_ok) ? rdata : '0;
      m_tuser <= (item_mode == MODE_READ || item_mode == MODE_WRITE) && !status.idx_ok;
    end
  end

  assign status.mode      = item_mode;
  assign status.idx_ok    = ({1'b0, item_idx} < line_len);
  assign status.step_ok   = (line_len >= MIN_STEP_LEN);
  assign status.line_len  = line_len;
  assign status.pipe_busy = rd_valid | win_valid | lap_valid | prod_valid;
  assign status.out_free  = out_free;

endmodule

FILE: design/heat_diffusion_step_1d_unit.sv
// Top level of the 1-D explicit heat diffusion step unit.
// Instantiates hds_ctrl and hds_datapath; depends on hds_pkg.
//
// Usage:
//  - Input stream s_*: s_tuser carries the mode (write cell, advance one time
//    step, read cell); s_tdata carries cell index and write value.
//  - Output stream m_*: one word per input word; m_tdata is the cell value
//    for a good read, zero otherwise; m_tuser flags a read or write index at or
//    beyond the line length.
//  - Config channel cfg_*: register 0 is gain (Q0.16), register 1 is the line
//    length. Always ready; write only while the unit is idle.
//  - Timing: a read or write passes through execute and finish states before its
//    result is registered, and the next word is taken once back in idle; a step's
//    length is set by the single read port of the cell store walking one cell a cycle
//    through a four-stage update pipe. s_tready is high only when idle.
//  - Reset: gain returns to 655, line length to 1024, and the cell store is
//    swept to zero one cell a cycle, with s_tready low meanwhile.
//  - Stall: a result waits in the output register; the next item may be taken
//    and worked on, and its result is held until the register frees.
`timescale 1ns / 1ps

module heat_diffusion_step_1d_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [9:0] cell_index, [41:10] cell_value, [47:42] zero
  input  logic [hds_pkg::S_TDATA_W-1:0]  s_tdata,
  // [1:0] mode
  input  logic [hds_pkg::S_TUSER_W-1:0]  s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [31:0] read_value
  output logic [hds_pkg::M_TDATA_W-1:0]  m_tdata,
  // [0] status
  output logic                           m_tuser,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hds_pkg::CFG_DATA_W-1:0] cfg_data
);
  import hds_pkg::*;

  hds_cmd_t    cmd;
  hds_status_t status;

  assign cfg_ready = 1'b1;

  hds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .status   (status)
  );

  hds_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

FILE: dv/tb_heat_diffusion_step_1d_unit.sv
// Self-checking testbench for heat_diffusion_step_1d_unit: a queue-fed stream driver,
// a line predictor that checks every output word, and config writes between phases.
// Depends on hds_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb_heat_diffusion_step_1d_unit;
  import hds_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int QUIET_LIMIT = 20000;
  localparam int LONG_HOLD = 80;
  localparam logic [VALUE_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [ADDR_W-1:0]  index;
    logic [VALUE_W-1:0] value;
  } cell_cmd_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               status;
  } cell_answer_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;
  logic [S_TUSER_W-1:0]  s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  m_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor state
  logic signed [VALUE_W-1:0] line_cells [MAX_CELLS];
  logic [GAIN_W-1:0]         gain_q;
  logic [LEN_W-1:0]          line_len;

  cell_cmd_t    cell_cmds [$];
  cell_answer_t cell_answers [$];
  cell_cmd_t    next_cmd;
  cell_answer_t got_answer;
  int           items_queued = 0;
  int           items_taken = 0;
  int           mismatches = 0;
  int           quiet_cycles = 0;
  logic         calm = 1'b0;
  int           hold_requests = 0;
  int           holds_done = 0;
  int           hold_left = 0;
  int           stall_left = 0;
  int           send_gap = 0;

  heat_diffusion_step_1d_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // One explicit time step; the left neighbor's pre-update value rides along.
  function automatic void diffuse_line();
    int     n;
    longint left_old, old, lap, prod, delta, sum, g;
    n = (line_len > MAX_CELLS) ? MAX_CELLS : int'(line_len);
    g = gain_q;
    if (n < 3) return;
    left_old = line_cells[0];
    for (int i = 1; i + 1 < n; i++) begin
      old   = line_cells[i];
      lap   = left_old + longint'(line_cells[i+1]) - 2 * old;
      prod  = g * lap;
      delta = (prod + 32768) >>> 16;
      sum   = old + delta;
      if (sum > 64'sd2147483647) line_cells[i] = VAL_MAX;
      else if (sum < -64'sd2147483648) line_cells[i] = VAL_MIN;
      else line_cells[i] = sum[VALUE_W-1:0];
      left_old = old;
    end
  endfunction

  function automatic cell_answer_t take_item(cell_cmd_t c);
    cell_answer_t a;
    int           n;
    n = (line_len > MAX_CELLS) ? MAX_CELLS : int'(line_len);
    a = '0;
    if (c.mode == MODE_WRITE || c.mode == MODE_READ) begin
      if (int'(c.index) >= n) a.status = 1'b1;
      else if (c.mode == MODE_WRITE) line_cells[c.index] = c.value;
      else a.value = line_cells[c.index];
    end else if (c.mode == MODE_STEP) begin
      diffuse_line();
    end
    return a;
  endfunction

  // stream driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap <= 0;
    end else if (s_tvalid && !s_tready) begin
      // hold the offered word
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      s_tvalid <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      send_gap <= $urandom_range(0, 2);
      s_tvalid <= 1'b0;
    end else if (cell_cmds.size() > 0) begin
      next_cmd = cell_cmds.pop_front();
      s_tvalid <= 1'b1;
      s_tuser  <= next_cmd.mode;
      s_tdata  <= {6'd0, next_cmd.value, next_cmd.index};
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // result receiver
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
      hold_left  <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (hold_requests != holds_done) begin
      // long back-pressure so the unit fills and stalls its input
      holds_done <= holds_done + 1;
      hold_left  <= LONG_HOLD;
      m_tready   <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 2);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (cell_answers.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual read_value %h status %b",
                   $time, m_tdata, m_tuser);
          mismatches++;
        end else begin
          got_answer = cell_answers.pop_front();
          if (m_tdata !== got_answer.value) begin
            $display("%0t: read_value mismatch, expected %h actual %h",
                     $time, got_answer.value, m_tdata);
            mismatches++;
          end
          if (m_tuser !== got_answer.status) begin
            $display("%0t: status mismatch, expected %b actual %b",
                     $time, got_answer.status, m_tuser);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        next_cmd.mode  = s_tuser;
        next_cmd.index = s_tdata[ADDR_W-1:0];
        next_cmd.value = s_tdata[ADDR_W +: VALUE_W];
        cell_answers.push_back(take_item(next_cmd));
        items_taken++;
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_cmd(input logic [MODE_W-1:0] m, input logic [ADDR_W-1:0] idx,
                          input logic [VALUE_W-1:0] v);
    cell_cmd_t c;
    c.mode  = m;
    c.index = idx;
    c.value = v;
    cell_cmds.push_back(c);
    items_queued++;
  endtask

  task automatic wait_idle();
    while (items_taken != items_queued || cell_answers.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_GAIN) gain_q = data[GAIN_W-1:0];
    else line_len = data[LEN_W-1:0];
  endtask

  // drain, then load both registers
  task automatic set_line(input int unsigned g, input int unsigned cells);
    wait_idle();
    write_reg(REG_GAIN, CFG_DATA_W'(g));
    write_reg(REG_CELLS, CFG_DATA_W'(cells));
  endtask

  task automatic push_random(input int count, input int step_pct);
    int          n, r;
    logic [MODE_W-1:0]  m;
    logic [ADDR_W-1:0]  idx;
    logic [VALUE_W-1:0] v;
    n = (line_len > MAX_CELLS) ? MAX_CELLS : int'(line_len);
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < step_pct) m = MODE_STEP;
      else if (r < step_pct + 4) m = MODE_SPARE;
      else if (r[0]) m = MODE_WRITE;
      else m = MODE_READ;
      // mostly in-range indexes, some anywhere to hit the length check
      if (n == 0 || $urandom_range(0, 6) == 0) idx = ADDR_W'($urandom_range(0, MAX_CELLS - 1));
      else idx = ADDR_W'($urandom_range(0, n - 1));
      case ($urandom_range(0, 5))
        0:       v = VAL_MAX;
        1:       v = VAL_MIN;
        2, 3:    v = $urandom;
        default: v = $urandom_range(0, 32'd26214400) - 32'd13107200;
      endcase
      push_cmd(m, idx, v);
    end
  endtask

  initial begin
    foreach (line_cells[i]) line_cells[i] = '0;
    gain_q   = GAIN_RESET;
    line_len = CELLS_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset contents, boundaries and extremes at full length
    push_cmd(MODE_READ, 10'd0, '0);
    push_cmd(MODE_READ, 10'd1023, '0);
    push_cmd(MODE_WRITE, 10'd0, 32'h00C8_0000);
    push_cmd(MODE_WRITE, 10'd1023, VAL_MAX);
    push_cmd(MODE_WRITE, 10'd1, VAL_MIN);
    push_cmd(MODE_WRITE, 10'd2, 32'hFFFF_FFFF);
    push_cmd(MODE_STEP, 10'd0, '0);
    push_cmd(MODE_READ, 10'd1, '0);
    push_cmd(MODE_READ, 10'd2, '0);
    push_cmd(MODE_READ, 10'd1022, '0);
    push_cmd(MODE_READ, 10'd1023, '0);
    push_cmd(MODE_SPARE, 10'h3FF, 32'hA5A5_5A5A);

    // line too short for any interior cell
    set_line(1, 2);
    push_cmd(MODE_STEP, 10'd0, '0);
    push_cmd(MODE_WRITE, 10'd2, 32'h1234_5678);
    push_cmd(MODE_READ, 10'd1, '0);
    push_cmd(MODE_READ, 10'd2, '0);

    // length above the store size clamps to the store
    set_line(1, 2047);
    push_cmd(MODE_STEP, 10'd0, '0);
    push_cmd(MODE_READ, 10'd1023, '0);

    set_line(GAIN_RESET, 0);
    push_cmd(MODE_READ, 10'd0, '0);

    // rounding: exactly half an LSB goes up, minus half goes to zero
    set_line(1, 3);
    push_cmd(MODE_WRITE, 10'd0, 32'd32768);
    push_cmd(MODE_WRITE, 10'd1, '0);
    push_cmd(MODE_WRITE, 10'd2, '0);
    push_cmd(MODE_STEP, 10'd0, '0);
    push_cmd(MODE_READ, 10'd1, '0);
    push_cmd(MODE_WRITE, 10'd0, 32'hFFFF_8000);
    push_cmd(MODE_STEP, 10'd0, '0);
    push_cmd(MODE_READ, 10'd1, '0);

    set_line(GAIN_RESET, MAX_CELLS);
    push_random(40, 5);
    set_line(0, 17);
    push_random(70, 20);
    set_line(32767, 3);
    push_random(60, 25);

    set_line($urandom_range(0, 32767), $urandom_range(3, 40));
    hold_requests <= hold_requests + 1;
    push_random(80, 20);

    set_line(32767, MAX_CELLS);
    push_random(30, 10);

    set_line($urandom_range(1, 2000), $urandom_range(4, 64));
    push_random(40, 20);
    wait_idle();
    push_random(40, 20);

    set_line(1, 1000);
    push_random(25, 8);
    set_line($urandom_range(0, 32767), $urandom_range(3, 12));
    push_random(90, 25);

    set_line(GAIN_RESET, 33);
    calm <= 1'b1;
    push_random(80, 20);

    wait_idle();
    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
